// ===== rtl/fis_pkg.sv =====
// Package for the frame interval statistics unit: field widths, constants,
// divider operand select codes and the controller/datapath command and status structs.
// No dependencies.
package fis_pkg;

  localparam int unsigned DefSampleDepth = 256;

  localparam int unsigned FtW     = 24;  // frame time
  localparam int unsigned TcW     = 16;  // tick count
  localparam int unsigned IdxW    = 8;   // sample index
  localparam int unsigned SumW    = 25;  // interval time sum
  localparam int unsigned TotW    = 24;  // interval frame count
  localparam int unsigned TickW   = 32;  // interval tick sum / rates
  localparam int unsigned CntOutW = 9;   // stored_count field
  localparam int unsigned InDataW = 48;
  localparam int unsigned OutDataW = 160;

  // Shared divider: dividend aligned to its top bit, one quotient bit per cycle
  localparam int unsigned DivNW    = 60;
  localparam int unsigned DivDW    = 25;
  localparam int unsigned DivCntW  = 6;

  localparam logic [27:0] RateScale = 28'd256000000;

  localparam logic [FtW-1:0]  RiReset = 24'd500000;
  localparam logic [1:0]      RegReportInterval = 2'd0;

  // Input item kinds
  localparam logic OpAdd  = 1'b0;
  localparam logic OpRead = 1'b1;

  typedef enum logic [1:0] {
    DIV_MEAN = 2'd0,
    DIV_TICK = 2'd1,
    DIV_FPS  = 2'd2
  } div_sel_e;

  typedef struct packed {
    logic     load_in;    // capture the input transfer
    logic     update;     // ring write / read, interval sums
    logic     check;      // evaluate latch condition
    logic     div_start;
    div_sel_e div_sel;
    logic     cap_mean;
    logic     cap_tick;
    logic     apply;      // latch / select reported values
    logic     cap_fps;
    logic     out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic div_done;
    logic need_run;       // running mean and tick rate must be computed
    logic out_free;       // output register can take a result
    logic first_latched;
  } dp_status_t;

endpackage

// ===== rtl/fis_div.sv =====
// Restoring divider for the frame interval statistics unit, one quotient bit per cycle.
// Depends on fis_pkg.
module fis_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [fis_pkg::DivCntW-1:0] steps_i,     // quotient bits to produce
  input  logic [fis_pkg::DivNW-1:0]  dividend_i,  // aligned to the top bit
  input  logic [fis_pkg::DivDW-1:0]  divisor_i,
  output logic [fis_pkg::DivNW-1:0]  quotient_o,
  output logic                       busy_o,
  output logic                       done_o
);
  import fis_pkg::*;

  logic [DivDW:0]     rem_q, rem_d;
  logic [DivNW-1:0]   dq_q, dq_d;
  logic [DivDW-1:0]   dvs_q;
  logic [DivCntW-1:0] cnt_q;
  logic               busy_q, done_q;
  logic [DivDW:0]     shifted;
  logic [DivDW+1:0]   diff;

  // one trial subtraction per step
  always_comb begin
    shifted = {rem_q[DivDW-1:0], dq_q[DivNW-1]};
    diff    = {1'b0, shifted} - {2'b00, dvs_q};
    if (!diff[DivDW+1]) begin
      rem_d = diff[DivDW:0];
      dq_d  = {dq_q[DivNW-2:0], 1'b1};
    end else begin
      rem_d = shifted;
      dq_d  = {dq_q[DivNW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= steps_i;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == DivCntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dq_q  <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      dq_q  <= dq_d;
    end
  end

  assign quotient_o = dq_q;
  assign busy_o     = busy_q;
  assign done_o     = done_q;

endmodule

// ===== rtl/fis_datapath.sv =====
// Datapath of the frame interval statistics unit: sample ring, interval sums,
// latched results, shared divider and output register. Depends on fis_pkg, fis_div.
module fis_datapath #(
  parameter int unsigned SAMPLE_DEPTH = fis_pkg::DefSampleDepth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  fis_pkg::ctrl_cmd_t            cmd_i,
  output fis_pkg::dp_status_t           status_o,
  input  logic [fis_pkg::FtW-1:0]       report_interval_i,
  input  logic                          op_i,
  input  logic [fis_pkg::InDataW-1:0]   in_data_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [fis_pkg::OutDataW-1:0]  out_data_o
);
  import fis_pkg::*;

  localparam int unsigned AW = (SAMPLE_DEPTH > 1) ? $clog2(SAMPLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(SAMPLE_DEPTH + 1);

  // captured input item
  logic            op_q;
  logic [FtW-1:0]  ft_q;
  logic [TcW-1:0]  tc_q;
  logic [IdxW-1:0] idx_q;

  // ring and its bookkeeping
  logic [FtW-1:0] ring_mem [SAMPLE_DEPTH];
  logic [AW-1:0]  slot_q;
  logic [CW-1:0]  count_q;
  logic [FtW-1:0] rd_q;
  logic           hit_q;

  // interval state
  logic [SumW-1:0]  time_sum_q;
  logic [TotW-1:0]  total_q;
  logic [TickW-1:0] tick_sum_q;
  logic [FtW-1:0]   longest_q;
  logic [FtW-1:0]   lat_avg_q, lat_long_q;
  logic [TickW-1:0] lat_rate_q;
  logic             first_q;
  logic             latch_now_q;

  // division results and current report
  logic [FtW-1:0]   mean_q, cur_avg_q, cur_long_q;
  logic [TickW-1:0] trate_q, cur_rate_q, fps_q;
  logic [59:0]      prod_q;

  // output register
  logic                out_valid_q;
  logic [OutDataW-1:0] out_q;

  logic [SumW:0]      sum_ext;
  logic [TickW:0]     tick_ext;
  logic [DivNW-1:0]   div_nd, quot;
  logic [DivDW-1:0]   div_dv;
  logic [DivCntW-1:0] div_steps;
  logic               div_busy, div_done;
  logic               sample_ok;

  assign sum_ext   = {1'b0, time_sum_q} + {2'b00, ft_q};
  assign tick_ext  = {1'b0, tick_sum_q} + {17'd0, tc_q};
  assign sample_ok = (32'(idx_q) < 32'(count_q)) && (32'(idx_q) < 32'(SAMPLE_DEPTH));

  // capture input transfer
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      op_q  <= op_i;
      ft_q  <= in_data_i[23:0];
      tc_q  <= in_data_i[39:24];
      idx_q <= in_data_i[47:40];
    end
  end

  // sample ring memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      if (op_q == OpAdd) ring_mem[slot_q] <= ft_q;
      rd_q <= ring_mem[AW'(idx_q)];
    end
  end

  // scaled tick sum for the rate division
  always_ff @(posedge clk_i) begin
    prod_q <= 60'(tick_sum_q) * 60'(RateScale);
  end

  // interval and latched state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q      <= '0;
      count_q     <= '0;
      hit_q       <= 1'b0;
      time_sum_q  <= '0;
      total_q     <= '0;
      tick_sum_q  <= '0;
      longest_q   <= '0;
      lat_avg_q   <= '0;
      lat_long_q  <= '0;
      lat_rate_q  <= '0;
      first_q     <= 1'b0;
      latch_now_q <= 1'b0;
    end else begin
      if (cmd_i.update) begin
        if (op_q == OpAdd) begin
          hit_q  <= 1'b0;
          slot_q <= (32'(slot_q) == SAMPLE_DEPTH - 1) ? '0 : slot_q + 1'b1;
          if (32'(count_q) < SAMPLE_DEPTH) count_q <= count_q + 1'b1;
          time_sum_q <= sum_ext[SumW] ? '1 : sum_ext[SumW-1:0];
          if (total_q != '1) total_q <= total_q + 1'b1;
          tick_sum_q <= tick_ext[TickW] ? '1 : tick_ext[TickW-1:0];
          if (ft_q > longest_q) longest_q <= ft_q;
        end else begin
          hit_q <= sample_ok;
        end
      end
      if (cmd_i.check) begin
        latch_now_q <= (op_q == OpAdd) && (time_sum_q >= {1'b0, report_interval_i});
      end
      if (cmd_i.apply && latch_now_q) begin
        lat_avg_q  <= mean_q;
        lat_long_q <= longest_q;
        lat_rate_q <= trate_q;
        first_q    <= 1'b1;
        time_sum_q <= '0;
        total_q    <= '0;
        tick_sum_q <= '0;
        longest_q  <= '0;
      end
    end
  end

  // divider operand select
  always_comb begin
    case (cmd_i.div_sel)
      DIV_MEAN: begin
        div_nd    = {time_sum_q, 35'd0};
        div_dv    = {1'b0, total_q};
        div_steps = DivCntW'(SumW);
      end
      DIV_TICK: begin
        div_nd    = prod_q;
        div_dv    = time_sum_q;
        div_steps = DivCntW'(DivNW);
      end
      DIV_FPS: begin
        div_nd    = {RateScale, 32'd0};
        div_dv    = {1'b0, cur_avg_q};
        div_steps = DivCntW'(28);
      end
      default: begin
        div_nd    = '0;
        div_dv    = '0;
        div_steps = '0;
      end
    endcase
  end

  fis_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .steps_i    (div_steps),
    .dividend_i (div_nd),
    .divisor_i  (div_dv),
    .quotient_o (quot),
    .busy_o     (div_busy),
    .done_o     (div_done)
  );

  // division results (zero divisor gives zero, mean and tick rate saturate) and reported values
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_mean) begin
      if (total_q == '0)          mean_q <= '0;
      else if (quot[59:24] != '0) mean_q <= '1;
      else                        mean_q <= quot[23:0];
    end
    if (cmd_i.cap_tick) begin
      if (time_sum_q == '0)       trate_q <= '0;
      else if (quot[59:32] != '0) trate_q <= '1;
      else                        trate_q <= quot[31:0];
    end
    if (cmd_i.cap_fps) begin
      fps_q <= (cur_avg_q == '0) ? '0 : quot[31:0];
    end
    if (cmd_i.apply) begin
      if (latch_now_q || !first_q) begin
        cur_avg_q  <= mean_q;
        cur_long_q <= longest_q;
        cur_rate_q <= trate_q;
      end else begin
        cur_avg_q  <= lat_avg_q;
        cur_long_q <= lat_long_q;
        cur_rate_q <= lat_rate_q;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q <= {6'd0,
                first_q,
                hit_q ? rd_q : {FtW{1'b0}},
                (32'(count_q) < SAMPLE_DEPTH) ? 8'd0 : 8'(slot_q),
                9'(count_q),
                cur_rate_q,
                cur_long_q,
                fps_q,
                cur_avg_q};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign status_o.div_busy      = div_busy;
  assign status_o.div_done      = div_done;
  assign status_o.need_run      = (op_q == OpAdd && time_sum_q >= {1'b0, report_interval_i})
                                  || !first_q;
  assign status_o.out_free      = !out_valid_q || out_ready_i;
  assign status_o.first_latched = first_q;

endmodule

// ===== rtl/fis_ctrl.sv =====
// Controller of the frame interval statistics unit: sequences update, divisions
// and the output load. Depends on fis_pkg.
module fis_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  fis_pkg::dp_status_t status_i,
  output fis_pkg::ctrl_cmd_t  cmd_o
);
  import fis_pkg::*;

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StUpd   = 4'd1;
  localparam logic [3:0] StChk   = 4'd2;
  localparam logic [3:0] StMean  = 4'd3;
  localparam logic [3:0] StTick  = 4'd4;
  localparam logic [3:0] StApply = 4'd5;
  localparam logic [3:0] StFpsGo = 4'd6;
  localparam logic [3:0] StFps   = 4'd7;
  localparam logic [3:0] StDone  = 4'd8;

  logic [3:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d = StUpd;
        end
      end
      StUpd: begin
        cmd_o.update = 1'b1;
        state_d = StChk;
      end
      // running values are needed before the first latch or on a latch
      StChk: begin
        cmd_o.check = 1'b1;
        if (status_i.need_run) begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = DIV_MEAN;
          state_d = StMean;
        end else begin
          state_d = StApply;
        end
      end
      StMean: begin
        if (status_i.div_done) begin
          cmd_o.cap_mean  = 1'b1;
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = DIV_TICK;
          state_d = StTick;
        end
      end
      StTick: begin
        cmd_o.div_sel = DIV_TICK;
        if (status_i.div_done) begin
          cmd_o.cap_tick = 1'b1;
          state_d = StApply;
        end
      end
      StApply: begin
        cmd_o.apply = 1'b1;
        state_d = StFpsGo;
      end
      StFpsGo: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_FPS;
        state_d = StFps;
      end
      StFps: begin
        cmd_o.div_sel = DIV_FPS;
        if (status_i.div_done) begin
          cmd_o.cap_fps = 1'b1;
          state_d = StDone;
        end
      end
      StDone: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/frame_interval_statistics_unit.sv =====
// Top level of the frame interval statistics unit: stream ports, APB register.
// Depends on fis_pkg, fis_ctrl, fis_datapath.
//
// One item is processed at a time. While running values are needed (before the
// first report latches, and on the item that latches), an add or read item uses
// the shared one-bit-per-cycle divider for 25 quotient bits of mean frame time,
// 60 of tick rate and 28 of frames per second. Once a report has latched, other
// items run the frames-per-second division only. A finished result sits in an
// output register, so the next item is taken while it waits. report_interval
// sits at byte address 0 of the APB port and may only be written while idle.
module frame_interval_statistics_unit #(
  parameter int unsigned SAMPLE_DEPTH = fis_pkg::DefSampleDepth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // APB configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  // input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [fis_pkg::InDataW-1:0]   s_axis_tdata,  // frame_time, tick_count, sample_index
  input  logic                          s_axis_tuser,  // op
  // result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // average_frame_time, frames_per_second, longest_frame_time, ticks_per_second,
  // stored_count, oldest_index, sample_value, interval_done
  output logic [fis_pkg::OutDataW-1:0]  m_axis_tdata
);
  import fis_pkg::*;

  logic [FtW-1:0] report_interval_q;
  ctrl_cmd_t      cmd;
  dp_status_t     status;

  // configuration register
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      report_interval_q <= RiReset;
    end else if (psel && penable && pwrite && paddr[2] == RegReportInterval[0]) begin
      report_interval_q <= pwdata[FtW-1:0];
    end
  end
  assign prdata = (paddr[2] == RegReportInterval[0]) ? {8'd0, report_interval_q} : 32'd0;

  fis_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  fis_datapath #(
    .SAMPLE_DEPTH (SAMPLE_DEPTH)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .report_interval_i (report_interval_q),
    .op_i              (s_axis_tuser),
    .in_data_i         (s_axis_tdata),
    .out_ready_i       (m_axis_tready),
    .out_valid_o       (m_axis_tvalid),
    .out_data_o        (m_axis_tdata)
  );

  // once a report has latched it stays latched
  assert property (@(posedge clk_i) disable iff (!rst_ni) !$fell(status.first_latched))
    else $error("interval_done cleared after latching");

  // the divider is never restarted while busy
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd.div_start |-> !status.div_busy)
    else $error("divider started while busy");

  // no new item is taken while a division runs
  assert property (@(posedge clk_i) disable iff (!rst_ni) s_axis_tready |-> !status.div_busy)
    else $error("input ready during division");

endmodule
